// ===== rtl/core/oesf_pkg.sv =====
`timescale 1ns / 1ps
// oesf_pkg: shared types and constants for the offline event store-and-forward block
// no dependencies; used by the interfaces' users, front, back and top level

package oesf_pkg;

  // default ring size, one slot always stays empty
  localparam int QUEUE_DEPTH_DEF = 64;

  // depth of the request queue between front and back
  localparam int FQ_DEPTH = 2;

  // configuration register reset values
  localparam logic [15:0] LINK_TIMEOUT_RST  = 16'd5000;
  localparam logic [15:0] SEND_INTERVAL_RST = 16'd3000;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 2'd1;

  // request opcodes
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // one stored door event, 34 bits
  typedef struct packed {
    logic       door_open;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } event_t;

  // classified request as it travels from front to back
  typedef struct packed {
    op_t    op;
    event_t evt;
  } item_t;

  // one result
  typedef struct packed {
    logic   event_sent;
    event_t evt;
    logic   link_up;
    logic   dropped;
  } res_t;

  // configuration values seen by the back end
  typedef struct packed {
    logic [15:0] link_timeout_ms;
    logic [15:0] send_interval_ms;
  } cfg_t;

  // saturating increment of a 16 bit millisecond counter
  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// ===== rtl/core/oesf_ifs.sv =====
`timescale 1ns / 1ps
// oesf_ifs: request, result and configuration channel interfaces
// depends on nothing; widths follow the event field widths

interface oesf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       door_open;
  logic [6:0] year_in;
  logic [3:0] month_in;
  logic [4:0] day_in;
  logic [4:0] hour_in;
  logic [5:0] minute_in;
  logic [5:0] second_in;

  modport source (output valid, op, door_open, year_in, month_in, day_in, hour_in,
                  minute_in, second_in, input ready);
  modport sink (input valid, op, door_open, year_in, month_in, day_in, hour_in,
                minute_in, second_in, output ready);
endinterface

interface oesf_out_if;
  logic       valid;
  logic       ready;
  logic       event_sent;
  logic       door_open_out;
  logic [6:0] year_out;
  logic [3:0] month_out;
  logic [4:0] day_out;
  logic [4:0] hour_out;
  logic [5:0] minute_out;
  logic [5:0] second_out;
  logic       link_up;
  logic       dropped;

  modport source (output valid, event_sent, door_open_out, year_out, month_out, day_out,
                  hour_out, minute_out, second_out, link_up, dropped, input ready);
  modport sink (input valid, event_sent, door_open_out, year_out, month_out, day_out,
                hour_out, minute_out, second_out, link_up, dropped, output ready);
endinterface

interface oesf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/offline_event_store_forward.sv =====
`timescale 1ns / 1ps
// offline_event_store_forward: store-and-forward ring for door events with link watchdog
// a request waits in the front queue, then the back end registers its result; a tick that pops
// also passes through S_POP; throughput: one request per cycle unless the result channel stalls
// or a popping tick holds the back end in S_POP (the event memory read is registered)
// reset: synchronous active-low; ring empty, link up, counters zero, timeout 5000, interval 3000
// depends on oesf_pkg, oesf_ifs, oesf_front, oesf_back

module offline_event_store_forward #(
  parameter int QUEUE_DEPTH = oesf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  oesf_in_if.sink     in_chan,
  oesf_out_if.source  out_chan,
  oesf_cfg_if.sink    cfg_chan
);
  import oesf_pkg::*;

  // configuration registers
  logic [15:0] tmo_r, tmo_nxt;
  logic [15:0] ivl_r, ivl_nxt;
  cfg_t        cfg;

  // front to back request queue
  item_t in_item;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // result side
  logic  res_valid;
  res_t  res;

  // config writes are always taken; unknown indexes are ignored
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    tmo_nxt = tmo_r;
    ivl_nxt = ivl_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_LINK_TIMEOUT:  tmo_nxt = cfg_chan.data;
        CFG_SEND_INTERVAL: ivl_nxt = cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= LINK_TIMEOUT_RST;
      ivl_r <= SEND_INTERVAL_RST;
    end else begin
      tmo_r <= tmo_nxt;
      ivl_r <= ivl_nxt;
    end
  end

  assign cfg.link_timeout_ms  = tmo_r;
  assign cfg.send_interval_ms = ivl_r;

  // classify the incoming request: the 2-bit code maps directly onto the opcode set
  assign in_item.op            = op_t'(in_chan.op);
  assign in_item.evt.door_open = in_chan.door_open;
  assign in_item.evt.year      = in_chan.year_in;
  assign in_item.evt.month     = in_chan.month_in;
  assign in_item.evt.day       = in_chan.day_in;
  assign in_item.evt.hour      = in_chan.hour_in;
  assign in_item.evt.minute    = in_chan.minute_in;
  assign in_item.evt.second    = in_chan.second_in;

  // front end: takes requests whenever its short queue has room
  oesf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back end: ring, watchdog counters and the result register
  oesf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (res_valid),
    .out_ready (out_chan.ready),
    .out_res   (res)
  );

  // result channel
  assign out_chan.valid         = res_valid;
  assign out_chan.event_sent    = res.event_sent;
  assign out_chan.door_open_out = res.evt.door_open;
  assign out_chan.year_out      = res.evt.year;
  assign out_chan.month_out     = res.evt.month;
  assign out_chan.day_out       = res.evt.day;
  assign out_chan.hour_out      = res.evt.hour;
  assign out_chan.minute_out    = res.evt.minute;
  assign out_chan.second_out    = res.evt.second;
  assign out_chan.link_up       = res.link_up;
  assign out_chan.dropped       = res.dropped;

endmodule

// ===== rtl/core/oesf_front.sv =====
`timescale 1ns / 1ps
// oesf_front: accepts already classified requests and queues them for the back end
// depends on oesf_pkg

module oesf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  oesf_pkg::item_t in_item,
  output logic            q_valid,
  output oesf_pkg::item_t q_item,
  input  logic            q_pop
);
  import oesf_pkg::*;

  localparam int PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(FQ_DEPTH + 1);

  item_t            q_r [FQ_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready = (cnt_r != CNT_W'(FQ_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ptr_inc(wp_r) : wp_r;
    rp_nxt  = pop ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_item;
    end
  end

endmodule

// ===== rtl/core/oesf_back.sv =====
`timescale 1ns / 1ps
// oesf_back: executes queued requests against the event ring and the link watchdog
// depends on oesf_pkg; holds the event memory and the result register

module oesf_back #(
  parameter int QUEUE_DEPTH = oesf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  oesf_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  oesf_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output oesf_pkg::res_t  out_res
);
  import oesf_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    S_RUN,
    S_POP
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             conn_r, conn_nxt;
  logic [15:0]      ack_ms_r, ack_ms_nxt;
  logic [15:0]      send_ms_r, send_ms_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  event_t           mem [QUEUE_DEPTH];
  event_t           rd_data_r;
  logic             wr_en;

  logic             go;
  logic [IDX_W-1:0] wr_inc;
  logic [IDX_W-1:0] rd_inc;
  logic [15:0]      ack_inc;
  logic [15:0]      send_inc;
  logic             conn_tick;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    ring_next = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign wr_inc    = ring_next(wr_idx_r);
  assign rd_inc    = ring_next(rd_idx_r);
  assign ack_inc   = sat_inc16(ack_ms_r);
  assign send_inc  = sat_inc16(send_ms_r);
  assign conn_tick = conn_r && !(ack_inc > cfg.link_timeout_ms);

  // a request runs only when the result register is free or emptying
  assign go    = (state_r == S_RUN) && q_valid && (!out_valid_r || out_ready);
  assign q_pop = go;

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    conn_nxt      = conn_r;
    ack_ms_nxt    = ack_ms_r;
    send_ms_nxt   = send_ms_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    wr_en         = 1'b0;

    unique case (state_r)
      S_RUN: begin
        if (go) begin
          res_nxt       = '0;
          out_valid_nxt = 1'b1;
          unique case (q_item.op)
            OP_ENQ: begin
              if (wr_inc == rd_idx_r) begin
                res_nxt.dropped = 1'b1;
              end else begin
                wr_en      = 1'b1;
                wr_idx_nxt = wr_inc;
              end
            end
            OP_ACK: begin
              conn_nxt   = 1'b1;
              ack_ms_nxt = '0;
            end
            OP_TICK: begin
              ack_ms_nxt  = ack_inc;
              send_ms_nxt = send_inc;
              conn_nxt    = conn_tick;
              if (conn_tick && (send_inc >= cfg.send_interval_ms)) begin
                send_ms_nxt = '0;
                if (rd_idx_r != wr_idx_r) begin
                  // memory read lands next cycle, result goes out from S_POP
                  rd_idx_nxt    = rd_inc;
                  state_nxt     = S_POP;
                  out_valid_nxt = 1'b0;
                end
              end
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
          res_nxt.link_up = conn_nxt;
        end
      end
      S_POP: begin
        res_nxt.event_sent = 1'b1;
        res_nxt.evt        = rd_data_r;
        res_nxt.link_up    = conn_r;
        res_nxt.dropped    = 1'b0;
        out_valid_nxt      = 1'b1;
        state_nxt          = S_RUN;
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      conn_r      <= 1'b1;
      ack_ms_r    <= '0;
      send_ms_r   <= '0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      conn_r      <= conn_nxt;
      ack_ms_r    <= ack_ms_nxt;
      send_ms_r   <= send_ms_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
    end
  end

  // event ring: one write port, one registered read port at the read index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx_r] <= q_item.evt;
    end
    rd_data_r <= mem[rd_idx_r];
  end

endmodule

// ===== rtl/core/oesf_checker.sv =====
`timescale 1ns / 1ps
// oesf_checker: port-level checks on the result channel of the top level
// bound to offline_event_store_forward; depends on oesf_ifs only through the bind

module oesf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       event_sent,
  input logic       door_open_out,
  input logic [3:0] month_out,
  input logic [4:0] day_out,
  input logic       link_up,
  input logic       dropped
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a result without a sent event carries an empty event
  a_empty_evt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !event_sent |-> month_out == 4'd0 && day_out == 5'd0 && !door_open_out)
    else $error("event fields set without a sent event");

  // an event is only forwarded with the link up
  a_sent_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_sent |-> link_up)
    else $error("event sent with link down");

  // one request cannot both drop and send
  a_drop_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(dropped && event_sent))
    else $error("drop and send in one result");

endmodule

bind offline_event_store_forward oesf_checker u_oesf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .event_sent    (out_chan.event_sent),
  .door_open_out (out_chan.door_open_out),
  .month_out     (out_chan.month_out),
  .day_out       (out_chan.day_out),
  .link_up       (out_chan.link_up),
  .dropped       (out_chan.dropped)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for offline_event_store_forward (door event ring, link watchdog)
// depends on oesf_pkg, oesf_ifs and the rtl top level; a scoreboard class predicts every result

module testbench;

  import oesf_pkg::*;

  localparam int RING_SLOTS = QUEUE_DEPTH_DEF;

  // predicts the result of every accepted request and holds those not yet seen
  class store_forward_board;
    event_t      ring [RING_SLOTS];
    int          wr_ptr;
    int          rd_ptr;
    logic        link;
    logic [15:0] since_ack;
    logic [15:0] since_send;
    logic [15:0] timeout_ms;
    logic [15:0] interval_ms;
    res_t        due_results [$];
    int          mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr      = 0;
      rd_ptr      = 0;
      link        = 1'b1;
      since_ack   = '0;
      since_send  = '0;
      timeout_ms  = LINK_TIMEOUT_RST;
      interval_ms = SEND_INTERVAL_RST;
      mismatches  = 0;
    endfunction

    function int step_ptr(int p);
      return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == CFG_LINK_TIMEOUT) timeout_ms = val;
      else if (idx == CFG_SEND_INTERVAL) interval_ms = val;
    endfunction

    function void note_request(item_t rq);
      res_t r;
      int   nxt;
      r = '0;
      case (rq.op)
        OP_ENQ: begin
          nxt = step_ptr(wr_ptr);
          if (nxt == rd_ptr) begin
            r.dropped = 1'b1;
          end else begin
            ring[wr_ptr] = rq.evt;
            wr_ptr = nxt;
          end
        end
        OP_ACK: begin
          link = 1'b1;
          since_ack = '0;
        end
        OP_TICK: begin
          if (since_ack != 16'hFFFF) since_ack = since_ack + 16'd1;
          if (since_send != 16'hFFFF) since_send = since_send + 16'd1;
          if (since_ack > timeout_ms) link = 1'b0;
          if (link && since_send >= interval_ms) begin
            since_send = '0;
            if (rd_ptr != wr_ptr) begin
              r.event_sent = 1'b1;
              r.evt = ring[rd_ptr];
              rd_ptr = step_ptr(rd_ptr);
            end
          end
        end
        default: ;
      endcase
      r.link_up = link;
      due_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      logic bad;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h at %0t", got, $realtime);
        return;
      end
      exp = due_results.pop_front();
      bad = (got.event_sent !== exp.event_sent) || (got.evt.door_open !== exp.evt.door_open) ||
            (got.evt.year !== exp.evt.year) || (got.evt.month !== exp.evt.month) ||
            (got.evt.day !== exp.evt.day) || (got.evt.hour !== exp.evt.hour) ||
            (got.evt.minute !== exp.evt.minute) || (got.evt.second !== exp.evt.second) ||
            (got.link_up !== exp.link_up) || (got.dropped !== exp.dropped);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected sent=%b open=%b y=%0d mo=%0d d=%0d h=%0d mi=%0d s=%0d up=%b drop=%b",
                   exp.event_sent, exp.evt.door_open, exp.evt.year, exp.evt.month, exp.evt.day,
                   exp.evt.hour, exp.evt.minute, exp.evt.second, exp.link_up, exp.dropped);
          $display("  actual   sent=%b open=%b y=%0d mo=%0d d=%0d h=%0d mi=%0d s=%0d up=%b drop=%b",
                   got.event_sent, got.evt.door_open, got.evt.year, got.evt.month, got.evt.day,
                   got.evt.hour, got.evt.minute, got.evt.second, got.link_up, got.dropped);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  oesf_in_if  in_bus ();
  oesf_out_if out_bus ();
  oesf_cfg_if cfg_bus ();

  store_forward_board sb = new();

  // receiver control: the stimulus asks for a long hold, the receiver serves and counts it
  int hold_asks;
  int hold_served;
  int hold_left;
  int mode_left;
  int rx_mode;

  offline_event_store_forward u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hang guard, well past the slowest legal run
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic item_t make_req(op_t op, event_t e);
    item_t rq;
    rq.op  = op;
    rq.evt = e;
    return rq;
  endfunction

  // mostly legal timestamps, a quarter of them raw bits over the full field widths
  function automatic event_t rand_event();
    event_t      e;
    logic [63:0] raw;
    if ($urandom_range(0, 3) == 0) begin
      raw = {$urandom(), $urandom()};
      e = raw[33:0];
    end else begin
      e.door_open = 1'($urandom_range(0, 1));
      e.year      = 7'($urandom_range(0, 99));
      e.month     = 4'($urandom_range(1, 12));
      e.day       = 5'($urandom_range(1, 31));
      e.hour      = 5'($urandom_range(0, 23));
      e.minute    = 6'($urandom_range(0, 59));
      e.second    = 6'($urandom_range(0, 59));
    end
    return e;
  endfunction

  // offer one request and hold it until taken; valid stays high for a following request
  task automatic push(input item_t rq);
    in_bus.valid     <= 1'b1;
    in_bus.op        <= rq.op;
    in_bus.door_open <= rq.evt.door_open;
    in_bus.year_in   <= rq.evt.year;
    in_bus.month_in  <= rq.evt.month;
    in_bus.day_in    <= rq.evt.day;
    in_bus.hour_in   <= rq.evt.hour;
    in_bus.minute_in <= rq.evt.minute;
    in_bus.second_in <= rq.evt.second;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_request(rq);
  endtask

  // stop offering and wait for every due result, then let the pipeline run dry
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers, back to back on the configuration channel
  task automatic program_link(input logic [15:0] timeout_val, input logic [15:0] interval_val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_LINK_TIMEOUT;
    cfg_bus.data  <= timeout_val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    sb.set_register(CFG_LINK_TIMEOUT, timeout_val);
    cfg_bus.index <= CFG_SEND_INTERVAL;
    cfg_bus.data  <= interval_val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    sb.set_register(CFG_SEND_INTERVAL, interval_val);
    cfg_bus.valid <= 1'b0;
  endtask

  // random traffic in bursts; weights in percent, three percent no-ops, the rest are ticks
  task automatic run_phase(input int n, input int enq_w, input int ack_w, input int gap_max);
    int   burst_left;
    int   gap;
    int   r;
    op_t  op;
    burst_left = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < enq_w) op = OP_ENQ;
      else if (r < enq_w + ack_w) op = OP_ACK;
      else if (r < enq_w + ack_w + 3) op = OP_NONE;
      else op = OP_TICK;
      push(make_req(op, rand_event()));
      burst_left--;
      gap = (burst_left == 0) ? $urandom_range(0, gap_max) : 0;
      if (burst_left == 0) burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else if ($urandom_range(0, 199) == 0) begin
        // sender pause until the block has answered everything
        in_bus.valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
      end
    end
  endtask

  // result side: ready follows one of four random patterns, each held for a random stretch, with rare long holds
  initial begin
    out_bus.ready <= 1'b0;
    hold_served = 0;
    hold_left = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (hold_asks != hold_served || $urandom_range(0, 3999) == 0) begin
        hold_served = hold_asks;
        hold_left = $urandom_range(300, 400);
        out_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        case (rx_mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 3) != 0);
          2: out_bus.ready <= 1'($urandom_range(0, 1));
          default: out_bus.ready <= ~out_bus.ready;
        endcase
      end
    end
  end

  // collect every taken result and hand it to the scoreboard
  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.event_sent     = out_bus.event_sent;
      got.evt.door_open  = out_bus.door_open_out;
      got.evt.year       = out_bus.year_out;
      got.evt.month      = out_bus.month_out;
      got.evt.day        = out_bus.day_out;
      got.evt.hour       = out_bus.hour_out;
      got.evt.minute     = out_bus.minute_out;
      got.evt.second     = out_bus.second_out;
      got.link_up        = out_bus.link_up;
      got.dropped        = out_bus.dropped;
      sb.check_result(got);
    end
  end

  // stimulus
  initial begin
    logic [15:0] timeout_val;
    logic [15:0] interval_val;
    int          enq_w;
    int          ack_w;
    int          gap_max;

    hold_asks = 0;
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.op        <= OP_NONE;
    in_bus.door_open <= 1'b0;
    in_bus.year_in   <= '0;
    in_bus.month_in  <= '0;
    in_bus.day_in    <= '0;
    in_bus.hour_in   <= '0;
    in_bus.minute_in <= '0;
    in_bus.second_in <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= CFG_LINK_TIMEOUT;
    cfg_bus.data     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings: unused op with a busy payload, then timestamp extremes
    push(make_req(OP_NONE, '1));
    push(make_req(OP_ENQ, '0));
    push(make_req(OP_ENQ, '1));
    push(make_req(OP_ENQ, event_t'{1'b1, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}));
    push(make_req(OP_ENQ, event_t'{1'b0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}));
    push(make_req(OP_ACK, '0));
    push(make_req(OP_TICK, '0));
    settle();

    // timeout of zero: the link drops on the first tick after an ack
    program_link(16'd0, 16'd0);
    push(make_req(OP_TICK, '0));
    push(make_req(OP_ACK, '0));
    push(make_req(OP_TICK, '0));
    settle();

    // interval of zero: every tick pops, the last two find the ring empty
    program_link(16'd100, 16'd0);
    push(make_req(OP_ACK, '0));
    for (int i = 0; i < 6; i++) push(make_req(OP_TICK, '0));
    settle();

    // a timeout of 65535 never fires, the link stays up through a run of ticks
    program_link(16'hFFFF, 16'hFFFF);
    push(make_req(OP_ACK, '0));
    push(make_req(OP_ENQ, rand_event()));
    for (int i = 0; i < 24; i++) push(make_req(OP_TICK, '0));
    settle();
    // interval of one: the next tick forwards the stored event
    program_link(16'hFFFE, 16'd1);
    push(make_req(OP_TICK, '0));
    push(make_req(OP_ACK, '0));
    settle();

    // random phases; the first fills the ring behind a long receiver hold
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        timeout_val  = 16'hFFFF;
        interval_val = 16'd40;
        enq_w   = 75;
        ack_w   = 5;
        gap_max = 0;
        hold_asks++;
      end else begin
        case ($urandom_range(0, 3))
          0: timeout_val = 16'd0;
          1: timeout_val = 16'($urandom_range(1, 8));
          2: timeout_val = 16'($urandom_range(9, 120));
          default: timeout_val = 16'hFFFF;
        endcase
        case ($urandom_range(0, 3))
          0: interval_val = 16'd0;
          1: interval_val = 16'd1;
          2: interval_val = 16'($urandom_range(2, 12));
          default: interval_val = 16'($urandom_range(13, 80));
        endcase
        enq_w   = $urandom_range(20, 70);
        ack_w   = $urandom_range(3, 20);
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      program_link(timeout_val, interval_val);
      run_phase(250, enq_w, ack_w, gap_max);
      settle();
    end

    // drain, then a few extra cycles for anything stray
    in_bus.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/oesf_pkg.sv
rtl/core/oesf_ifs.sv
rtl/core/oesf_front.sv
rtl/core/oesf_back.sv
rtl/core/offline_event_store_forward.sv
rtl/core/oesf_checker.sv
sim/testbench.sv
